/* rtl/smf_pkg.sv */
// Package for the sliding median filter: register codes, reset values,
// width helpers and the control struct shared by the top level and its cells.
// No dependencies.
package smf_pkg;

	localparam int DEF_MAX_WINDOW  = 15;
	localparam int DEF_SAMPLE_BITS = 16;

	localparam int WIDTH_BITS = 4;
	localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 4'd3;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// Register index as decoded from the word address bit.
	localparam logic REG_WINDOW_WIDTH = 1'b0;

	typedef struct packed {
		logic shift;   // a sample transfer shifts the delay line and restarts ranking
		logic step;    // one ranking step against the current candidate
	} smf_ctrl_t;

	// Bits for a count from 0 up to and including depth.
	function automatic int cnt_bits(input int depth);
		return $clog2(depth + 1);
	endfunction

	// Bits for an index from 0 to depth-1, never less than one.
	function automatic int idx_bits(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

	// Common width for comparing counts with the window width register.
	function automatic int cmp_bits(input int depth);
		return (cnt_bits(depth) > WIDTH_BITS) ? cnt_bits(depth) : WIDTH_BITS;
	endfunction

endpackage

/* rtl/smf_cell.sv */
// One cell of the median filter chain: a delay line tap, a scan register that
// feeds candidates toward cell 0, and a rank counter for the median search.
// Depends on smf_pkg.
module smf_cell #(
	parameter int MAX_WINDOW  = smf_pkg::DEF_MAX_WINDOW,
	parameter int SAMPLE_BITS = smf_pkg::DEF_SAMPLE_BITS,
	parameter int CELL_INDEX  = 0
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  smf_pkg::smf_ctrl_t                          ctrl,
	input  logic [smf_pkg::WIDTH_BITS-1:0]              width,
	input  logic [smf_pkg::idx_bits(MAX_WINDOW)-1:0]    step_idx,
	input  logic signed [SAMPLE_BITS-1:0]               win_in,
	input  logic signed [SAMPLE_BITS-1:0]               scan_in,
	input  logic signed [SAMPLE_BITS-1:0]               cand,
	output logic signed [SAMPLE_BITS-1:0]               win_out,
	output logic signed [SAMPLE_BITS-1:0]               scan_out,
	output logic                                        hit
);
	import smf_pkg::*;

	localparam int CNT_W = cnt_bits(MAX_WINDOW);
	localparam int IDX_W = idx_bits(MAX_WINDOW);
	localparam int CMP_W = cmp_bits(MAX_WINDOW);

	logic signed [SAMPLE_BITS-1:0] win_q;
	logic signed [SAMPLE_BITS-1:0] scan_q;
	logic [CNT_W-1:0]              rank_q;
	logic                          below;
	logic                          active;

	// Equal values are ordered by position so every rank in the window is unique.
	always_comb begin
		below  = (cand < win_q) || ((cand == win_q) && (step_idx < IDX_W'(CELL_INDEX)));
		active = CMP_W'(CELL_INDEX) < CMP_W'(width);
		hit    = active && (CMP_W'(rank_q) == CMP_W'(width[WIDTH_BITS-1:1]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (ctrl.shift) begin
			win_q <= win_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			scan_q <= win_in;
			rank_q <= '0;
		end else if (ctrl.step) begin
			scan_q <= scan_in;
			if (below) begin
				rank_q <= rank_q + CNT_W'(1);
			end
		end
	end

	assign win_out  = win_q;
	assign scan_out = scan_q;

endmodule

/* rtl/sliding_median_filter.sv */
// Sliding odd-window median filter: top level with the cell chain, the
// result sequencer, the output register and the APB register port.
// Depends on smf_pkg and smf_cell.
//
//  Channel   Dir   Fields (low bit first)
//  s_*       in    tdata: sample; tlast: final_sample
//  m_*       out   tdata: filtered; tlast: end_of_signal; tuser: width_error
//  APB       in    window_width at byte address 0
//
// A sample is transferred only while the sequencer is idle. When a median is due,
// a ranking pass follows, one step per window position, since the cells rank
// against one candidate per cycle. Each result then goes through the output
// register, and the next sample is taken only once the last result is loaded.
// A stalled output holds the sequencer; no clearing pass follows reset.
module sliding_median_filter #(
	parameter int MAX_WINDOW  = smf_pkg::DEF_MAX_WINDOW,
	parameter int SAMPLE_BITS = smf_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,   // sample
	input  logic                                   s_tlast,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]       m_tdata,   // filtered
	output logic                                   m_tlast,
	output logic                                   m_tuser,   // width_error
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [smf_pkg::APB_ADDR_W-1:0]         paddr,
	input  logic [smf_pkg::APB_DATA_W-1:0]         pwdata,
	output logic [smf_pkg::APB_DATA_W-1:0]         prdata,
	output logic                                   pready
);
	import smf_pkg::*;

	localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int CNT_W  = cnt_bits(MAX_WINDOW);
	localparam int IDX_W  = idx_bits(MAX_WINDOW);
	localparam int CMP_W  = cmp_bits(MAX_WINDOW);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RANK = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]            state_q;
	logic [WIDTH_BITS-1:0] width_q;
	logic [CNT_W-1:0]      seen_q;
	logic                  last_q;
	logic                  med_q;
	logic                  err_q;
	logic                  first_q;
	logic [IDX_W-1:0]      idx_q;
	logic [IDX_W-1:0]      j_q;

	logic                   m_tvalid_q;
	logic [SAMPLE_BITS-1:0] m_tdata_q;
	logic                   m_tlast_q;
	logic                   m_tuser_q;

	logic                   accept;
	logic                   cfg_wr;
	logic [CNT_W-1:0]       seen_nxt;
	logic [CMP_W-1:0]       wid_c;
	logic [CMP_W-1:0]       half_c;
	logic [CMP_W-1:0]       n_c;
	logic                   bad_width;
	logic                   main_c;
	logic                   med_c;
	logic                   emit_c;
	logic [IDX_W-1:0]       start_idx;
	logic                   out_free;
	logic                   load;
	logic                   done_c;
	logic [SAMPLE_BITS-1:0] median_c;
	logic [SAMPLE_BITS-1:0] raw_c;

	smf_ctrl_t                     ctrl;
	logic signed [SAMPLE_BITS-1:0] win_bus  [MAX_WINDOW];
	logic signed [SAMPLE_BITS-1:0] scan_bus [MAX_WINDOW];
	logic [MAX_WINDOW-1:0]         hit_vec;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign ctrl.shift = accept;
	assign ctrl.step  = (state_q == ST_RANK);

	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		logic signed [SAMPLE_BITS-1:0] win_in;
		logic signed [SAMPLE_BITS-1:0] scan_in;

		if (i == 0) begin : g_head
			assign win_in = s_tdata[SAMPLE_BITS-1:0];
		end else begin : g_body
			assign win_in = win_bus[i-1];
		end

		if (i == MAX_WINDOW - 1) begin : g_tail
			assign scan_in = '0;
		end else begin : g_link
			assign scan_in = scan_bus[i+1];
		end

		smf_cell #(
			.MAX_WINDOW  (MAX_WINDOW),
			.SAMPLE_BITS (SAMPLE_BITS),
			.CELL_INDEX  (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.width    (width_q),
			.step_idx (j_q),
			.win_in   (win_in),
			.scan_in  (scan_in),
			.cand     (scan_bus[0]),
			.win_out  (win_bus[i]),
			.scan_out (scan_bus[i]),
			.hit      (hit_vec[i])
		);
	end

	// Decisions for the sample being transferred, taken from the count after it.
	always_comb begin
		seen_nxt  = (seen_q < CNT_W'(MAX_WINDOW)) ? seen_q + CNT_W'(1) : seen_q;
		wid_c     = CMP_W'(width_q);
		half_c    = CMP_W'(width_q[WIDTH_BITS-1:1]);
		n_c       = CMP_W'(seen_nxt);
		bad_width = !width_q[0] || (wid_c > CMP_W'(MAX_WINDOW));
		main_c    = !bad_width && (n_c > half_c);
		med_c     = main_c && (n_c >= wid_c);
		emit_c    = bad_width ? s_tlast : (main_c || s_tlast);
		start_idx = main_c ? IDX_W'(half_c) : IDX_W'(n_c - CMP_W'(1));
	end

	// Exactly one active cell holds the rank of the middle after a full pass.
	always_comb begin
		median_c = '0;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			if (hit_vec[i]) begin
				median_c = median_c | win_bus[i];
			end
		end
	end

	assign raw_c    = win_bus[idx_q];
	assign out_free = !m_tvalid_q || m_tready;
	assign load     = (state_q == ST_EMIT) && out_free;
	assign done_c   = err_q || !last_q || (idx_q == '0);

	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[APB_ADDR_W-1] == REG_WINDOW_WIDTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			width_q    <= WIDTH_RESET;
			seen_q     <= '0;
			last_q     <= 1'b0;
			med_q      <= 1'b0;
			err_q      <= 1'b0;
			first_q    <= 1'b0;
			idx_q      <= '0;
			j_q        <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				width_q <= pwdata[WIDTH_BITS-1:0];
			end

			if (load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						seen_q  <= s_tlast ? '0 : seen_nxt;
						last_q  <= s_tlast;
						med_q   <= med_c;
						err_q   <= bad_width;
						first_q <= 1'b1;
						idx_q   <= start_idx;
						j_q     <= '0;
						if (emit_c) begin
							state_q <= med_c ? ST_RANK : ST_EMIT;
						end
					end
				end
				ST_RANK: begin
					if (CMP_W'(j_q) == wid_c - CMP_W'(1)) begin
						state_q <= ST_EMIT;
					end else begin
						j_q <= j_q + IDX_W'(1);
					end
				end
				ST_EMIT: begin
					if (load) begin
						if (done_c) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q - IDX_W'(1);
							first_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (err_q) begin
				m_tdata_q <= '0;
			end else if (first_q && med_q) begin
				m_tdata_q <= median_c;
			end else begin
				m_tdata_q <= raw_c;
			end
			m_tlast_q <= err_q || (last_q && (idx_q == '0));
			m_tuser_q <= err_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = DATA_W'(m_tdata_q);
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

	assign pready = 1'b1;
	assign prdata = (paddr[APB_ADDR_W-1] == REG_WINDOW_WIDTH) ? APB_DATA_W'(width_q) : '0;

`ifndef SYNTHESIS
	a_rank_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RANK) |-> (CMP_W'(j_q) < wid_c))
		else $error("ranking step beyond the window");

	a_median_unique: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_EMIT) && med_q && first_q) |-> $onehot(hit_vec))
		else $error("median rank not held by exactly one cell");

	a_error_ends_signal: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tlast)
		else $error("width error result without end of signal");

	a_count_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tlast) |=> (seen_q == '0))
		else $error("sample count not cleared after the last sample");

	a_busy_while_rank: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RANK) |-> !s_tready)
		else $error("sample transfer taken during a ranking pass");
`endif

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for sliding_median_filter: a directed stimulus table, then random
// signals over several window widths, every output transfer checked against the table row or the in-bench model.
// Depends on smf_pkg and the sliding_median_filter RTL.
module tb_top;
	import smf_pkg::*;

	localparam int SB            = DEF_SAMPLE_BITS;
	localparam int MAXW          = DEF_MAX_WINDOW;
	localparam int DATA_W        = ((SB + 7) / 8) * 8;
	localparam int SETTLE_CYCLES = 40;
	localparam int FLUSH_CYCLES  = 64;
	localparam int HOLD_CYCLES   = 300;
	localparam int SEG_WEIGHT    = 6;

	// Byte addresses on the APB port.
	localparam logic [APB_ADDR_W-1:0] ADDR_WIDTH_REG = 3'd0;
	localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED  = 3'd4;

	typedef struct packed {
		logic signed [SB-1:0] filtered;
		logic                 eos;
		logic                 err;
	} filt_out_t;

	typedef enum logic {STIM_SAMPLE, STIM_WIDTH} stim_kind_t;

	// A sample row carries the sample in the low bits of value; a width row carries pwdata.
	typedef struct packed {
		stim_kind_t            kind;
		logic [APB_ADDR_W-1:0] addr;
		logic [31:0]           value;
		logic                  last;
		logic                  typed;
		logic [SB-1:0]         exp_val;
		logic                  exp_eos;
		logic                  exp_err;
	} dir_row_t;

	localparam dir_row_t DIRECTED [31] = '{
		// Width 3 after reset: a one-sample signal leaves raw with end of signal.
		'{STIM_SAMPLE, ADDR_WIDTH_REG, 32'h7FFF, 1'b1, 1'b1, 16'h7FFF, 1'b1, 1'b0},
		'{STIM_SAMPLE, ADDR_WIDTH_REG, 32'h8000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
		'{STIM_SAMPLE, ADDR_WIDTH_REG, 32'h0005, 1'b0, 1'b1, 16'h8000, 1'b0, 1'b0},
		'{STIM_SAMPLE, ADDR_WIDTH_REG, 32'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
		'{STIM_SAMPLE, ADDR_WIDTH_REG, 32'hFFFF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
		'{STIM_SAMPLE, ADDR_WIDTH_REG, 32'h7FFF, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
		// Even width: only the last sample gives the error result.
		'{STIM_WIDTH,  ADDR_WIDTH_REG, 32'h0004, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
		'{STIM_SAMPLE, ADDR_WIDTH_REG, 32'h000A, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
		'{STIM_SAMPLE, ADDR_WIDTH_REG, 32'h0014, 1'b1, 1'b1, 16'h0000, 1'b1, 1'b1},
		'{STIM_WIDTH,  ADDR_WIDTH_REG, 32'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
		'{STIM_SAMPLE, ADDR_WIDTH_REG, 32'h1234, 1'b1, 1'b1, 16'h0000, 1'b1, 1'b1},
		// Width 1 written with the upper bits set; a write to an unmapped address is ignored.
		'{STIM_WIDTH,  ADDR_WIDTH_REG, 32'hFFFF_FFF1, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
		'{STIM_WIDTH,  ADDR_UNMAPPED,  32'h0000_0007, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
		'{STIM_SAMPLE, ADDR_WIDTH_REG, 32'hFFFB, 1'b0, 1'b1, 16'hFFFB, 1'b0, 1'b0},
		'{STIM_SAMPLE, ADDR_WIDTH_REG, 32'h0007, 1'b1, 1'b1, 16'h0007, 1'b1, 1'b0},
		// Widest window with a signal a little longer than half of it.
		'{STIM_WIDTH,  ADDR_WIDTH_REG, 32'h000F, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
		'{STIM_SAMPLE, ADDR_WIDTH_REG, 32'h8000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
		'{STIM_SAMPLE, ADDR_WIDTH_REG, 32'h7FFF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
		'{STIM_SAMPLE, ADDR_WIDTH_REG, 32'h0001, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
		'{STIM_SAMPLE, ADDR_WIDTH_REG, 32'hFFFF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
		'{STIM_SAMPLE, ADDR_WIDTH_REG, 32'h5555, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
		'{STIM_SAMPLE, ADDR_WIDTH_REG, 32'hAAAA, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
		'{STIM_SAMPLE, ADDR_WIDTH_REG, 32'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
		'{STIM_SAMPLE, ADDR_WIDTH_REG, 32'h8001, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
		'{STIM_SAMPLE, ADDR_WIDTH_REG, 32'h7FFE, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
		// Width changed from 5 to 3 in the middle of a signal.
		'{STIM_WIDTH,  ADDR_WIDTH_REG, 32'h0005, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
		'{STIM_SAMPLE, ADDR_WIDTH_REG, 32'h0030, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
		'{STIM_SAMPLE, ADDR_WIDTH_REG, 32'hFFD0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
		'{STIM_SAMPLE, ADDR_WIDTH_REG, 32'h0010, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
		'{STIM_WIDTH,  ADDR_WIDTH_REG, 32'h0003, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
		'{STIM_SAMPLE, ADDR_WIDTH_REG, 32'hFFF0, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0}
	};

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [DATA_W-1:0]     s_tdata  = '0;     // sample
	logic                  s_tlast  = 1'b0;   // final_sample
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [DATA_W-1:0]     m_tdata;           // filtered
	logic                  m_tlast;           // end_of_signal
	logic                  m_tuser;           // width_error
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [APB_ADDR_W-1:0] paddr    = '0;
	logic [APB_DATA_W-1:0] pwdata   = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	// Model state: delay line with the newest sample at entry 0.
	logic signed [SB-1:0]  hist [MAXW];
	int unsigned           seen_cnt;
	logic [WIDTH_BITS-1:0] cur_width;
	filt_out_t             step_out [$];
	filt_out_t             pending_outputs [$];

	int fail_cnt      = 0;
	int snd_idle_pct  = 0;
	int rcv_idle_pct  = 0;
	int hold_requests = 0;

	sliding_median_filter dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	always #1 clk = ~clk;

	initial begin
		#400000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic logic signed [SB-1:0] window_median(input int w);
		logic signed [SB-1:0] srt [MAXW];
		logic signed [SB-1:0] v;
		int j;
		for (int i = 0; i < w; i++) begin
			v = hist[i];
			j = i;
			while (j > 0 && srt[j-1] > v) begin
				srt[j] = srt[j-1];
				j--;
			end
			srt[j] = v;
		end
		return srt[w/2];
	endfunction

	// Advances the filter model by one sample and leaves its outputs in step_out.
	task automatic filter_step(input logic [SB-1:0] smp, input logic last);
		int w;
		int half;
		int n;
		filt_out_t tail;
		step_out.delete();
		w = cur_width;
		half = w / 2;
		for (int i = MAXW - 1; i > 0; i--)
			hist[i] = hist[i-1];
		hist[0] = smp;
		if (seen_cnt < MAXW)
			seen_cnt++;
		n = seen_cnt;
		if (w % 2 == 0 || w > MAXW) begin
			if (last) begin
				step_out.push_back('{filtered: '0, eos: 1'b1, err: 1'b1});
				seen_cnt = 0;
			end
			return;
		end
		if (n > half) begin
			step_out.push_back('{filtered: (n >= w) ? window_median(w) : hist[half],
				eos: 1'b0, err: 1'b0});
			if (last) begin
				for (int i = half; i > 0; i--)
					step_out.push_back('{filtered: hist[i-1], eos: 1'b0, err: 1'b0});
			end
		end else if (last) begin
			for (int i = n; i > 0; i--)
				step_out.push_back('{filtered: hist[i-1], eos: 1'b0, err: 1'b0});
		end
		if (last) begin
			if (step_out.size() > 0) begin
				tail = step_out.pop_back();
				tail.eos = 1'b1;
				step_out.push_back(tail);
			end
			seen_cnt = 0;
		end
	endtask

	function automatic logic [SB-1:0] pick_sample();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($urandom_range(8)) - 16'd4;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [WIDTH_BITS-1:0] pick_width();
		if ($urandom_range(7) == 0)
			return 4'($urandom_range(7) * 2);
		return 4'($urandom_range(7) * 2 + 1);
	endfunction

	// Offers one sample; on its transfer, queues what the table row or the model expects from it.
	task automatic send_sample(input logic [SB-1:0] smp, input logic last,
			input logic typed, input filt_out_t typed_out);
		while ($urandom_range(99) < snd_idle_pct) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= DATA_W'(smp);
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		filter_step(smp, last);
		if (typed)
			pending_outputs.push_back(typed_out);
		else
			foreach (step_out[i]) pending_outputs.push_back(step_out[i]);
	endtask

	task automatic drain_outputs();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_outputs.size() != 0)
			@(posedge clk);
	endtask

	// Drains the expected outputs and lets the filter go idle before a width write.
	task automatic settle();
		drain_outputs();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic read_width_reg();
		logic [APB_DATA_W-1:0] rd;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_WIDTH_REG;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd !== APB_DATA_W'(cur_width)) begin
			$display("%0t: window_width readback: expected %0d, actual %0d",
				$time, cur_width, rd);
			fail_cnt++;
		end
	endtask

	task automatic program_width(input logic [APB_ADDR_W-1:0] addr,
			input logic [APB_DATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == ADDR_WIDTH_REG)
			cur_width = data[WIDTH_BITS-1:0];
		read_width_reg();
	endtask

	// Receiver: random back-pressure, plus a long hold whenever the stimulus asks for one.
	int hold_served = 0;
	int hold_left   = 0;
	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served++;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	always @(posedge clk) begin
		filt_out_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_outputs.size() == 0) begin
				$display("%0t: unexpected output: expected none, actual %0d/%b/%b",
					$time, $signed(m_tdata[SB-1:0]), m_tlast, m_tuser);
				fail_cnt++;
			end else begin
				want = pending_outputs.pop_front();
				if (m_tdata[SB-1:0] !== want.filtered) begin
					$display("%0t: filtered: expected %0d, actual %0d",
						$time, want.filtered, $signed(m_tdata[SB-1:0]));
					fail_cnt++;
				end
				if (m_tlast !== want.eos) begin
					$display("%0t: end_of_signal: expected %b, actual %b",
						$time, want.eos, m_tlast);
					fail_cnt++;
				end
				if (m_tuser !== want.err) begin
					$display("%0t: width_error: expected %b, actual %b",
						$time, want.err, m_tuser);
					fail_cnt++;
				end
			end
		end
	end

	initial begin
		int weight;
		int sig_len;
		logic last;
		foreach (hist[i]) hist[i] = '0;
		seen_cnt  = 0;
		cur_width = WIDTH_RESET;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		read_width_reg();

		snd_idle_pct = 29;
		rcv_idle_pct = 46;
		foreach (DIRECTED[r]) begin
			if (DIRECTED[r].kind == STIM_WIDTH) begin
				settle();
				program_width(DIRECTED[r].addr, DIRECTED[r].value);
			end else begin
				send_sample(DIRECTED[r].value[SB-1:0], DIRECTED[r].last, DIRECTED[r].typed,
					'{filtered: DIRECTED[r].exp_val, eos: DIRECTED[r].exp_eos,
					err: DIRECTED[r].exp_err});
			end
		end

		for (int phase = 0; phase < 3; phase++) begin
			snd_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 46 : 0;
			rcv_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 29 : 0;
			for (int seg = 0; seg < 3; seg++) begin
				settle();
				program_width(ADDR_WIDTH_REG, ($urandom & 32'hFFFF_FFF0) |
					APB_DATA_W'((phase == 2 && seg == 0) ? 4'd15 : pick_width()));
				// Stall the output with the widest window so the input side backs up.
				if (phase == 2 && seg == 0)
					hold_requests++;
				weight = 0;
				while (weight < SEG_WEIGHT) begin
					sig_len = $urandom_range(24, 1);
					for (int k = 0; k < sig_len; k++) begin
						last = (k == sig_len - 1) || ($urandom_range(19) == 0);
						send_sample(pick_sample(), last, 1'b0, '0);
						// Items at an even width only count half, as they rarely give output.
						weight += cur_width[0] ? 2 : 1;
						if (phase == 1 && seg == 1 && weight == 4)
							drain_outputs();
					end
				end
			end
		end

		drain_outputs();
		repeat (FLUSH_CYCLES) @(posedge clk);
		if (fail_cnt == 0 && pending_outputs.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* sim.f */
rtl/smf_pkg.sv
rtl/smf_cell.sv
rtl/sliding_median_filter.sv
verif/tb_top.sv
